[hw/rtl/mepwm_pkg.sv]
package mepwm_pkg;

	typedef enum logic [1:0] {
		CMD_TICK  = 2'd0,
		CMD_WRITE = 2'd1,
		CMD_READ  = 2'd2
	} cmd_t;

	localparam logic [7:0] REG_PRESCALE = 8'h00;
	localparam logic [7:0] REG_PERIOD   = 8'h04;
	localparam logic [7:0] REG_EN_LO    = 8'h08;
	localparam logic [7:0] REG_EN_HI    = 8'h0C;
	localparam logic [7:0] REG_RISE0    = 8'h10;
	localparam logic [7:0] REG_FALL0    = 8'h14;
	localparam logic [7:0] FALL_OFS     = REG_FALL0 - REG_RISE0;

	localparam int unsigned CH_IDX_BITS = 5;

	typedef enum logic [2:0] {
		SEL_NONE,
		SEL_PRESCALE,
		SEL_PERIOD,
		SEL_EN_LO,
		SEL_EN_HI,
		SEL_RISE,
		SEL_FALL
	} sel_t;

	typedef struct packed {
		logic [1:0] cmd;
		logic [7:0] addr;
		logic [7:0] wdata;
	} req_t;

	typedef struct packed {
		sel_t                   sel;
		logic [CH_IDX_BITS-1:0] ch;
	} dec_t;

	function automatic dec_t decode_addr(input logic [7:0] addr);
		dec_t       d;
		logic [7:0] off;
		d.sel = SEL_NONE;
		d.ch  = '0;
		off   = addr - REG_RISE0;
		case (addr)
			REG_PRESCALE: d.sel = SEL_PRESCALE;
			REG_PERIOD:   d.sel = SEL_PERIOD;
			REG_EN_LO:    d.sel = SEL_EN_LO;
			REG_EN_HI:    d.sel = SEL_EN_HI;
			default: begin
				// channel pairs sit on an 8-byte stride above the first rise register
				if (addr >= REG_RISE0) begin
					d.ch = off[7:3];
					if (off[2:0] == 3'd0)
						d.sel = SEL_RISE;
					else if (off[2:0] == FALL_OFS[2:0])
						d.sel = SEL_FALL;
				end
			end
		endcase
		return d;
	endfunction

endpackage

[hw/rtl/mepwm_regfile.sv]
module mepwm_regfile #(
	parameter int CHANNELS   = 16,
	parameter int COUNT_BITS = 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  commit,
	input  mepwm_pkg::req_t       req,
	output logic [7:0]            rdata,
	output logic [COUNT_BITS-1:0] step_nxt,
	output logic [CHANNELS-1:0]   en_nxt,
	output logic [COUNT_BITS-1:0] rise_nxt [CHANNELS],
	output logic [COUNT_BITS-1:0] fall_nxt [CHANNELS]
);

	logic [COUNT_BITS-1:0] prescale_q, period_q, presc_cnt_q, step_q;
	logic [COUNT_BITS-1:0] prescale_nxt, period_nxt, presc_cnt_nxt;
	logic [CHANNELS-1:0]   en_q;
	logic [COUNT_BITS-1:0] rise_q [CHANNELS];
	logic [COUNT_BITS-1:0] fall_q [CHANNELS];

	mepwm_pkg::dec_t       dec;
	logic                  is_wr, is_rd, is_tick;
	logic [COUNT_BITS+7:0] wext;
	logic [COUNT_BITS-1:0] wcount;
	logic [CHANNELS+15:0]  en_ext;
	logic [15:0]           en_full, en_wr;
	logic [COUNT_BITS+7:0] presc_ext, period_ext, edge_ext;
	logic [COUNT_BITS-1:0] edge_rd;

	assign dec     = mepwm_pkg::decode_addr(req.addr);
	assign is_tick = (req.cmd == mepwm_pkg::CMD_TICK);
	assign is_wr   = (req.cmd == mepwm_pkg::CMD_WRITE);
	assign is_rd   = (req.cmd == mepwm_pkg::CMD_READ);

	// byte writes fill the low bits only
	assign wext   = {{COUNT_BITS{1'b0}}, req.wdata};
	assign wcount = wext[COUNT_BITS-1:0];

	assign en_ext  = {16'h0000, en_q};
	assign en_full = en_ext[15:0];

	always_comb begin
		prescale_nxt  = prescale_q;
		period_nxt    = period_q;
		presc_cnt_nxt = presc_cnt_q;
		step_nxt      = step_q;
		en_wr         = en_full;
		for (int i = 0; i < CHANNELS; i++) begin
			rise_nxt[i] = rise_q[i];
			fall_nxt[i] = fall_q[i];
		end
		if (is_tick) begin
			if (presc_cnt_q >= prescale_q) begin
				presc_cnt_nxt = '0;
				if (step_q >= period_q)
					step_nxt = '0;
				else
					step_nxt = step_q + 1'b1;
			end else begin
				presc_cnt_nxt = presc_cnt_q + 1'b1;
			end
		end
		if (is_wr) begin
			case (dec.sel)
				mepwm_pkg::SEL_PRESCALE: prescale_nxt = wcount;
				mepwm_pkg::SEL_PERIOD:   period_nxt   = wcount;
				mepwm_pkg::SEL_EN_LO:    en_wr[7:0]   = req.wdata;
				mepwm_pkg::SEL_EN_HI:    en_wr[15:8]  = req.wdata;
				mepwm_pkg::SEL_RISE: begin
					for (int i = 0; i < CHANNELS; i++)
						if (dec.ch == mepwm_pkg::CH_IDX_BITS'(i))
							rise_nxt[i] = wcount;
				end
				mepwm_pkg::SEL_FALL: begin
					for (int i = 0; i < CHANNELS; i++)
						if (dec.ch == mepwm_pkg::CH_IDX_BITS'(i))
							fall_nxt[i] = wcount;
				end
				default: ;
			endcase
		end
		en_nxt = en_wr[CHANNELS-1:0];
	end

	// edge count read mux; channels that do not exist read as zero
	always_comb begin
		edge_rd = '0;
		for (int i = 0; i < CHANNELS; i++) begin
			if (dec.ch == mepwm_pkg::CH_IDX_BITS'(i)) begin
				if (dec.sel == mepwm_pkg::SEL_RISE)
					edge_rd = rise_q[i];
				else if (dec.sel == mepwm_pkg::SEL_FALL)
					edge_rd = fall_q[i];
			end
		end
	end

	assign presc_ext  = {8'h00, prescale_q};
	assign period_ext = {8'h00, period_q};
	assign edge_ext   = {8'h00, edge_rd};

	always_comb begin
		rdata = 8'h00;
		if (is_rd) begin
			case (dec.sel)
				mepwm_pkg::SEL_PRESCALE: rdata = presc_ext[7:0];
				mepwm_pkg::SEL_PERIOD:   rdata = period_ext[7:0];
				mepwm_pkg::SEL_EN_LO:    rdata = en_full[7:0];
				mepwm_pkg::SEL_EN_HI:    rdata = en_full[15:8];
				mepwm_pkg::SEL_RISE,
				mepwm_pkg::SEL_FALL:     rdata = edge_ext[7:0];
				default:                 rdata = 8'h00;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prescale_q  <= '0;
			period_q    <= '0;
			presc_cnt_q <= '0;
			step_q      <= '0;
			en_q        <= '0;
			for (int i = 0; i < CHANNELS; i++) begin
				rise_q[i] <= '0;
				fall_q[i] <= '0;
			end
		end else if (commit) begin
			prescale_q  <= prescale_nxt;
			period_q    <= period_nxt;
			presc_cnt_q <= presc_cnt_nxt;
			step_q      <= step_nxt;
			en_q        <= en_nxt;
			for (int i = 0; i < CHANNELS; i++) begin
				rise_q[i] <= rise_nxt[i];
				fall_q[i] <= fall_nxt[i];
			end
		end
	end

endmodule

[hw/rtl/mepwm_wave.sv]
module mepwm_wave #(
	parameter int CHANNELS   = 16,
	parameter int COUNT_BITS = 8
) (
	input  logic [COUNT_BITS-1:0] step,
	input  logic [CHANNELS-1:0]   en,
	input  logic [15:0]           mapped,
	input  logic [COUNT_BITS-1:0] rise [CHANNELS],
	input  logic [COUNT_BITS-1:0] fall [CHANNELS],
	output logic [15:0]           pwm
);

	logic [CHANNELS-1:0]  hi;
	logic [CHANNELS+15:0] pwm_ext;

	// rise<fall: high inside [rise, fall); fall<rise: inverted window; equal: low
	always_comb begin
		for (int i = 0; i < CHANNELS; i++) begin
			if (rise[i] < fall[i])
				hi[i] = (step >= rise[i]) && (step < fall[i]);
			else if (fall[i] < rise[i])
				hi[i] = (step >= rise[i]) || (step < fall[i]);
			else
				hi[i] = 1'b0;
		end
	end

	assign pwm_ext = {16'h0000, hi & en & mapped[CHANNELS-1:0]};
	assign pwm     = pwm_ext[15:0];

endmodule

[hw/rtl/multichannel_edge_pwm_registers_core.sv]
// channel | handshake          | payload
// in      | in_valid/in_stall  | cmd, addr, wdata
// out     | out_valid/out_stall| rdata, pwm_out
// cfg     | cfg_wr_en          | cfg_wr_data (mapped outputs)
//
// One transaction per cycle sustained while the result is not stalled.
// The input register holds the transaction; register update, read mux and the
// per-channel edge compare sit between it and the result register.
// Reset clears valid flags, settings and counters; mapped outputs reset to all ones.
// A stalled result holds the input register; no transaction is dropped.
module multichannel_edge_pwm_registers_core #(
	parameter int CHANNELS   = 16,
	parameter int COUNT_BITS = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [15:0] cfg_wr_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  cmd,
	input  logic [7:0]  addr,
	input  logic [7:0]  wdata,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  rdata,
	output logic [15:0] pwm_out
);

	logic            valid_s1, valid_s2;
	mepwm_pkg::req_t req_s1;
	logic [7:0]      rdata_s2;
	logic [15:0]     pwm_s2;
	logic [15:0]     mapped_q;

	logic                  out_free, adv, accept;
	logic [7:0]            rdata_c;
	logic [15:0]           pwm_c;
	logic [COUNT_BITS-1:0] step_nxt;
	logic [CHANNELS-1:0]   en_nxt;
	logic [COUNT_BITS-1:0] rise_nxt [CHANNELS];
	logic [COUNT_BITS-1:0] fall_nxt [CHANNELS];

	assign out_free = !valid_s2 || !out_stall;
	assign adv      = valid_s1 && out_free;
	assign in_stall = valid_s1 && !out_free;
	assign accept   = in_valid && !in_stall;

	mepwm_regfile #(
		.CHANNELS   (CHANNELS),
		.COUNT_BITS (COUNT_BITS)
	) u_regs (
		.clk      (clk),
		.arst_n   (arst_n),
		.commit   (adv),
		.req      (req_s1),
		.rdata    (rdata_c),
		.step_nxt (step_nxt),
		.en_nxt   (en_nxt),
		.rise_nxt (rise_nxt),
		.fall_nxt (fall_nxt)
	);

	// outputs reflect the state after this transaction is applied
	mepwm_wave #(
		.CHANNELS   (CHANNELS),
		.COUNT_BITS (COUNT_BITS)
	) u_wave (
		.step   (step_nxt),
		.en     (en_nxt),
		.mapped (mapped_q),
		.rise   (rise_nxt),
		.fall   (fall_nxt),
		.pwm    (pwm_c)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			mapped_q <= 16'hFFFF;
		end else begin
			if (accept)
				valid_s1 <= 1'b1;
			else if (adv)
				valid_s1 <= 1'b0;
			if (adv)
				valid_s2 <= 1'b1;
			else if (out_free)
				valid_s2 <= 1'b0;
			if (cfg_wr_en)
				mapped_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (accept)
			req_s1 <= '{cmd: cmd, addr: addr, wdata: wdata};
		if (adv) begin
			rdata_s2 <= rdata_c;
			pwm_s2   <= pwm_c;
		end
	end

	assign out_valid = valid_s2;
	assign rdata     = rdata_s2;
	assign pwm_out   = pwm_s2;

endmodule

[hw/rtl/mepwm_checker.sv]
module mepwm_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic [7:0]  rdata,
	input logic [15:0] pwm_out
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(rdata) && $stable(pwm_out))
		else $error("stalled result changed");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled without a stalled result");

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) ##1 (!out_valid || !out_stall) |=> out_valid)
		else $error("accepted transaction did not reach the output");

endmodule

bind multichannel_edge_pwm_registers_core mepwm_checker u_chk (.*);
